@@ rtl/core/sqlts_pkg.sv @@
// sqlts_pkg: types, codes and byte classes shared by the SQL token scanner.
// Depends on nothing; every scanner module imports it.
`default_nettype none

package sqlts_pkg;

  localparam int OUT_POS_W  = 32;
  localparam int OUT_LINE_W = 24;
  localparam int OUT_COL_W  = 16;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic ERR_UNTERM = 1'b0;
  localparam logic ERR_UNEXP  = 1'b1;

  localparam logic [3:0] TT_IDENT  = 4'd0;
  localparam logic [3:0] TT_NUMBER = 4'd1;
  localparam logic [3:0] TT_STRING = 4'd2;
  localparam logic [3:0] TT_COMMA  = 4'd3;
  localparam logic [3:0] TT_SEMI   = 4'd4;
  localparam logic [3:0] TT_LPAREN = 4'd5;
  localparam logic [3:0] TT_RPAREN = 4'd6;
  localparam logic [3:0] TT_STAR   = 4'd7;
  localparam logic [3:0] TT_EQUAL  = 4'd8;
  localparam logic [3:0] TT_GREATER = 4'd9;
  localparam logic [3:0] TT_LESS   = 4'd10;
  localparam logic [3:0] TT_PLUS   = 4'd11;
  localparam logic [3:0] TT_MINUS  = 4'd12;
  localparam logic [3:0] TT_PARAM  = 4'd13;
  localparam logic [3:0] TT_END    = 4'd14;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_DEAD
  } mode_t;

  typedef enum logic [1:0] {
    REC_VALUE = 2'd0,
    REC_CLOSE = 2'd1,
    REC_ERROR = 2'd2
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t  kind;
    logic [3:0] tt;
    logic       err;
    logic       sel_cur;
  } rec_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0]  pos;
    logic [OUT_LINE_W-1:0] line;
    logic [OUT_COL_W-1:0]  col;
  } where_t;

  typedef struct packed {
    logic [1:0]     n;
    rec_t [2:0]     rec;
    logic [7:0]     b;
    where_t         tok;
    where_t         cur;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] tt;
  } punct_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {[8'h41:8'h5A]}) || (b inside {[8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_ident_part(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_US) || (b == CH_DOT);
  endfunction

  function automatic punct_t punct_type(input logic [7:0] b);
    punct_t p;
    p.hit = 1'b1;
    case (b)
      CH_COMMA:  p.tt = TT_COMMA;
      CH_SEMI:   p.tt = TT_SEMI;
      CH_LPAREN: p.tt = TT_LPAREN;
      CH_RPAREN: p.tt = TT_RPAREN;
      CH_STAR:   p.tt = TT_STAR;
      CH_EQUAL:  p.tt = TT_EQUAL;
      CH_GT:     p.tt = TT_GREATER;
      CH_LT:     p.tt = TT_LESS;
      CH_PLUS:   p.tt = TT_PLUS;
      CH_MINUS:  p.tt = TT_MINUS;
      CH_QMARK:  p.tt = TT_PARAM;
      default: begin
        p.hit = 1'b0;
        p.tt  = TT_IDENT;
      end
    endcase
    return p;
  endfunction

  function automatic rec_t make_rec(input rec_kind_t kind, input logic [3:0] tt,
                                    input logic err, input logic sel_cur);
    rec_t r;
    r.kind    = kind;
    r.tt      = tt;
    r.err     = err;
    r.sel_cur = sel_cur;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sqlts_front.sv @@
// sqlts_front: accepts input beats, keeps scan mode and counters, and turns each
// record-yielding beat into one command of up to three records. Depends on sqlts_pkg.
`default_nettype none

module sqlts_front import sqlts_pkg::*; #(
  parameter int POS_WIDTH    = 32,
  parameter int LINE_WIDTH   = 24,
  parameter int COLUMN_WIDTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       q_full,
  output logic            cmd_push,
  output cmd_t            cmd
);

  mode_t                   mode_r, mode_nxt;
  logic [POS_WIDTH-1:0]    pos_r, pos_nxt;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt;
  logic [COLUMN_WIDTH-1:0] col_r, col_nxt;
  where_t                  tstart_r, tstart_nxt;

  logic       acc;
  logic [7:0] b;
  where_t     cur;
  punct_t     pt;

  logic [1:0]  idle_n;
  rec_t [1:0]  idle_rec;
  mode_t       idle_mode;
  logic        idle_adv;
  logic        idle_mark;

  logic [1:0]  n;
  rec_t [2:0]  rec;
  logic        adv;
  logic        mark;
  logic        clear;
  logic        cont;
  logic [3:0]  tt_tok;

  assign acc = in_push && !q_full;
  assign b   = in_char_byte;
  assign pt  = punct_type(b);

  assign cur.pos  = OUT_POS_W'(pos_r);
  assign cur.line = OUT_LINE_W'(line_r);
  assign cur.col  = OUT_COL_W'(col_r);

  // scan one byte from idle; the start of any new token is the current place
  always_comb begin
    idle_n    = 2'd0;
    idle_rec  = '0;
    idle_mode = MODE_IDLE;
    idle_adv  = 1'b0;
    idle_mark = 1'b0;
    if (is_space(b)) begin
      idle_adv = 1'b1;
    end else begin
      idle_mark = 1'b1;
      if (is_alpha(b) || (b == CH_US)) begin
        idle_n      = 2'd1;
        idle_rec[0] = make_rec(REC_VALUE, TT_IDENT, 1'b0, 1'b1);
        idle_mode   = MODE_IDENT;
        idle_adv    = 1'b1;
      end else if (is_digit(b)) begin
        idle_n      = 2'd1;
        idle_rec[0] = make_rec(REC_VALUE, TT_NUMBER, 1'b0, 1'b1);
        idle_mode   = MODE_NUMBER;
        idle_adv    = 1'b1;
      end else if (b == CH_QUOTE) begin
        idle_mode = MODE_STRING;
        idle_adv  = 1'b1;
      end else if (pt.hit) begin
        idle_n      = 2'd2;
        idle_rec[0] = make_rec(REC_VALUE, pt.tt, 1'b0, 1'b1);
        idle_rec[1] = make_rec(REC_CLOSE, pt.tt, 1'b0, 1'b1);
        idle_adv    = 1'b1;
      end else begin
        idle_n      = 2'd1;
        idle_rec[0] = make_rec(REC_ERROR, TT_IDENT, ERR_UNEXP, 1'b1);
        idle_mode   = MODE_DEAD;
      end
    end
  end

  always_comb begin
    n        = 2'd0;
    rec      = '0;
    mode_nxt = mode_r;
    adv      = 1'b0;
    mark     = 1'b0;
    clear    = 1'b0;
    tt_tok   = (mode_r == MODE_IDENT) ? TT_IDENT : TT_NUMBER;
    cont     = (mode_r == MODE_IDENT) ? is_ident_part(b) : (is_digit(b) || (b == CH_DOT));
    if (in_kind == KIND_END) begin
      clear = 1'b1;
      case (mode_r)
        MODE_DEAD: begin
        end
        MODE_STRING, MODE_ESCAPE: begin
          n      = 2'd1;
          rec[0] = make_rec(REC_ERROR, TT_IDENT, ERR_UNTERM, 1'b0);
        end
        MODE_IDENT, MODE_NUMBER: begin
          n      = 2'd2;
          rec[0] = make_rec(REC_CLOSE, tt_tok, 1'b0, 1'b0);
          rec[1] = make_rec(REC_CLOSE, TT_END, 1'b0, 1'b1);
        end
        default: begin
          n      = 2'd1;
          rec[0] = make_rec(REC_CLOSE, TT_END, 1'b0, 1'b1);
        end
      endcase
    end else begin
      case (mode_r)
        MODE_DEAD: begin
        end
        MODE_IDENT, MODE_NUMBER: begin
          if (cont) begin
            n      = 2'd1;
            rec[0] = make_rec(REC_VALUE, tt_tok, 1'b0, 1'b0);
            adv    = 1'b1;
          end else begin
            rec[0]   = make_rec(REC_CLOSE, tt_tok, 1'b0, 1'b0);
            rec[2:1] = idle_rec;
            n        = 2'd1 + idle_n;
            mode_nxt = idle_mode;
            adv      = idle_adv;
            mark     = idle_mark;
          end
        end
        MODE_STRING: begin
          adv = 1'b1;
          if (b == CH_QUOTE) begin
            n        = 2'd1;
            rec[0]   = make_rec(REC_CLOSE, TT_STRING, 1'b0, 1'b0);
            mode_nxt = MODE_IDLE;
          end else if (b == CH_BSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            n      = 2'd1;
            rec[0] = make_rec(REC_VALUE, TT_STRING, 1'b0, 1'b0);
          end
        end
        MODE_ESCAPE: begin
          n        = 2'd1;
          rec[0]   = make_rec(REC_VALUE, TT_STRING, 1'b0, 1'b0);
          mode_nxt = MODE_STRING;
          adv      = 1'b1;
        end
        default: begin
          rec[1:0] = idle_rec;
          n        = idle_n;
          mode_nxt = idle_mode;
          adv      = idle_adv;
          mark     = idle_mark;
        end
      endcase
    end
  end

  // counters saturate at the top of their width
  always_comb begin
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    tstart_nxt = tstart_r;
    if (clear) begin
      pos_nxt         = '0;
      line_nxt        = LINE_WIDTH'(1);
      col_nxt         = COLUMN_WIDTH'(1);
      tstart_nxt.pos  = '0;
      tstart_nxt.line = OUT_LINE_W'(1);
      tstart_nxt.col  = OUT_COL_W'(1);
    end else begin
      if (mark) begin
        tstart_nxt = cur;
      end
      if (adv) begin
        pos_nxt = (&pos_r) ? pos_r : pos_r + POS_WIDTH'(1);
        if (b == CH_NL) begin
          line_nxt = (&line_r) ? line_r : line_r + LINE_WIDTH'(1);
          col_nxt  = COLUMN_WIDTH'(1);
        end else begin
          col_nxt = (&col_r) ? col_r : col_r + COLUMN_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_IDLE;
      pos_r           <= '0;
      line_r          <= LINE_WIDTH'(1);
      col_r           <= COLUMN_WIDTH'(1);
      tstart_r.pos    <= '0;
      tstart_r.line   <= OUT_LINE_W'(1);
      tstart_r.col    <= OUT_COL_W'(1);
    end else if (acc) begin
      mode_r   <= clear ? MODE_IDLE : mode_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      tstart_r <= tstart_nxt;
    end
  end

  assign cmd_push = acc && (n != 2'd0);
  assign cmd.n    = n;
  assign cmd.rec  = rec;
  assign cmd.b    = b;
  assign cmd.tok  = tstart_r;
  assign cmd.cur  = cur;

endmodule

`default_nettype wire

@@ rtl/core/sqlts_queue.sv @@
// sqlts_queue: short command queue between the scanner front and back.
// Depends on sqlts_pkg for the command type and depth.
`default_nettype none

module sqlts_queue import sqlts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      head_valid
);

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sqlts_back.sv @@
// sqlts_back: expands queued commands into result records into an output
// register read as a queue, one per cycle unless stalled. Depends on sqlts_pkg.
`default_nettype none

module sqlts_back import sqlts_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  cmd_t                        head,
  input  wire logic                   head_valid,
  output logic                        q_pop,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output logic [1:0]                  out_record_kind,
  output logic [7:0]                  out_value_byte,
  output logic [3:0]                  out_token_type,
  output logic [OUT_POS_W-1:0]        out_start_pos,
  output logic [OUT_LINE_W-1:0]       out_start_line,
  output logic [OUT_COL_W-1:0]        out_start_column,
  output logic                        out_error_code,
  output logic                        out_last
);

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] kind_r;
  logic [7:0] vb_r;
  logic [3:0] tt_r;
  where_t     where_r;
  logic       err_r;
  logic       last_r;

  rec_t   rec;
  where_t where_sel;
  logic   rec_last;
  logic   load;
  logic   taken;

  assign rec       = head.rec[idx_r];
  assign where_sel = rec.sel_cur ? head.cur : head.tok;
  assign rec_last  = (idx_r == head.n - 2'd1);
  assign taken     = out_pop && valid_r;
  assign load      = head_valid && (!valid_r || out_pop);
  assign q_pop     = load && rec_last;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = rec_last ? 2'd0 : idx_r + 2'd1;
    end else if (taken) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= rec.kind;
      vb_r    <= (rec.kind == REC_VALUE) ? head.b : 8'h00;
      tt_r    <= rec.tt;
      where_r <= where_sel;
      err_r   <= rec.err;
      last_r  <= rec_last;
    end
  end

  assign out_empty        = !valid_r;
  assign out_record_kind  = kind_r;
  assign out_value_byte   = vb_r;
  assign out_token_type   = tt_r;
  assign out_start_pos    = where_r.pos;
  assign out_start_line   = where_r.line;
  assign out_start_column = where_r.col;
  assign out_error_code   = err_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

@@ rtl/core/sql_token_scanner_top.sv @@
// sql_token_scanner_top: streaming SQL lexer, one text byte per input beat.
// Depends on sqlts_pkg, sqlts_front, sqlts_queue and sqlts_back.
//
// Input channel: drive in_kind/in_char_byte with in_push high; a beat is taken
// at an edge where in_full is low. in_kind 0 carries a text byte, 1 ends the
// statement and returns the scan state to its reset values.
// Result channel: while out_empty is low the oldest record is on the out_ ports;
// out_pop at such an edge takes it. Each input beat gives zero to three
// records, the final one flagged by out_last; value bytes of a token come first,
// its close record after.
// A record passes through the command queue and then the output register.
// Throughput: one input beat per cycle while each beat gives at most one record
// and the receiver pops; the back end issues one record per cycle unless the
// receiver stalls, so a beat with several records holds the queue head until its
// last one goes out. A four-entry queue between front and back absorbs bursts.
// Reset (rst_n low at a clock edge) empties the queue and output register and
// returns the scanner to idle with the position at 0 and line and column at 1.
// When the receiver stalls the output record holds, the queue fills and
// in_full rises; no record is lost.
`default_nettype none

module sql_token_scanner_top import sqlts_pkg::*; #(
  parameter int POS_WIDTH    = 32,
  parameter int LINE_WIDTH   = 24,
  parameter int COLUMN_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic                  in_kind,
  input  wire logic [7:0]            in_char_byte,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic [1:0]                 out_record_kind,
  output logic [7:0]                 out_value_byte,
  output logic [3:0]                 out_token_type,
  output logic [OUT_POS_W-1:0]       out_start_pos,
  output logic [OUT_LINE_W-1:0]      out_start_line,
  output logic [OUT_COL_W-1:0]       out_start_column,
  output logic                       out_error_code,
  output logic                       out_last
);

  cmd_t push_cmd;
  cmd_t head;
  logic cmd_push;
  logic q_full;
  logic q_pop;
  logic head_valid;

  assign in_full = q_full;

  sqlts_front #(
    .POS_WIDTH    (POS_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_kind      (in_kind),
    .in_char_byte (in_char_byte),
    .q_full       (q_full),
    .cmd_push     (cmd_push),
    .cmd          (push_cmd)
  );

  sqlts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head),
    .head_valid (head_valid)
  );

  sqlts_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .head_valid       (head_valid),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_record_kind  (out_record_kind),
    .out_value_byte   (out_value_byte),
    .out_token_type   (out_token_type),
    .out_start_pos    (out_start_pos),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

@@ rtl/core/sqlts_checker.sv @@
// sqlts_checker: port-level checks on the SQL token scanner, bound to the top.
// Depends on sqlts_pkg and sql_token_scanner_top.
`default_nettype none

module sqlts_checker import sqlts_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_push,
  input wire logic                  in_full,
  input wire logic                  in_kind,
  input wire logic [7:0]            in_char_byte,
  input wire logic                  out_empty,
  input wire logic                  out_pop,
  input wire logic [1:0]            out_record_kind,
  input wire logic [7:0]            out_value_byte,
  input wire logic [3:0]            out_token_type,
  input wire logic [OUT_POS_W-1:0]  out_start_pos,
  input wire logic [OUT_LINE_W-1:0] out_start_line,
  input wire logic [OUT_COL_W-1:0]  out_start_column,
  input wire logic                  out_error_code,
  input wire logic                  out_last
);

  a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (out_empty && !in_full))
    else $error("scanner not clean after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_record_kind) &&
      $stable(out_value_byte) && $stable(out_start_pos) && $stable(out_last)))
    else $error("stalled record changed");

  a_nonvalue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_record_kind != REC_VALUE)) |-> (out_value_byte == 8'h00))
    else $error("value byte set on a non-value record");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_record_kind == REC_ERROR)) |-> (out_last && (out_token_type == TT_IDENT)))
    else $error("error record not final or typed");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_record_kind == REC_CLOSE) && (out_token_type == TT_END)) |-> out_last)
    else $error("end token not final record");

endmodule

bind sql_token_scanner_top sqlts_checker u_sqlts_checker (.*);

`default_nettype wire

@@ bench/sqlts_stream_checker.sv @@
// sqlts_stream_checker: predicts the scanner's record stream from the accepted input
// beats and compares every popped record, field by field, with the oldest prediction.
// Depends on sqlts_pkg for the mode, record, token, error and character codes.
module sqlts_stream_checker import sqlts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic                  in_kind,
  input  logic [7:0]            in_char_byte,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic [1:0]            out_record_kind,
  input  logic [7:0]            out_value_byte,
  input  logic [3:0]            out_token_type,
  input  logic [OUT_POS_W-1:0]  out_start_pos,
  input  logic [OUT_LINE_W-1:0] out_start_line,
  input  logic [OUT_COL_W-1:0]  out_start_column,
  input  logic                  out_error_code,
  input  logic                  out_last,
  output int                    fail_count,
  output int                    due_count,
  output int                    matched_count
);

  localparam logic [OUT_POS_W-1:0]  POS_TOP  = '1;
  localparam logic [OUT_LINE_W-1:0] LINE_TOP = '1;
  localparam logic [OUT_COL_W-1:0]  COL_TOP  = '1;
  localparam logic [OUT_LINE_W-1:0] LINE_FIRST = OUT_LINE_W'(1);
  localparam logic [OUT_COL_W-1:0]  COL_FIRST  = OUT_COL_W'(1);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  typedef struct packed {
    rec_kind_t             kind;
    logic [7:0]            vbyte;
    logic [3:0]            tt;
    logic [OUT_POS_W-1:0]  pos;
    logic [OUT_LINE_W-1:0] line;
    logic [OUT_COL_W-1:0]  col;
    logic                  err;
    logic                  last;
  } lex_record_t;

  lex_record_t due_records[$];
  lex_record_t beat_records[$];

  mode_t                 scan_state;
  logic [OUT_POS_W-1:0]  at_pos,  tok_pos;
  logic [OUT_LINE_W-1:0] at_line, tok_line;
  logic [OUT_COL_W-1:0]  at_col,  tok_col;

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z);
  endfunction

  function automatic bit is_numeral(input logic [7:0] b);
    return b >= CH_DIG_0 && b <= CH_DIG_9;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit is_name_char(input logic [7:0] b);
    return is_letter(b) || is_numeral(b) || b == CH_US || b == CH_DOT;
  endfunction

  function automatic bit punct_of(input logic [7:0] b, output logic [3:0] tt);
    tt = TT_IDENT;
    punct_of = 1'b1;
    case (b)
      CH_COMMA:  tt = TT_COMMA;
      CH_SEMI:   tt = TT_SEMI;
      CH_LPAREN: tt = TT_LPAREN;
      CH_RPAREN: tt = TT_RPAREN;
      CH_STAR:   tt = TT_STAR;
      CH_EQUAL:  tt = TT_EQUAL;
      CH_GT:     tt = TT_GREATER;
      CH_LT:     tt = TT_LESS;
      CH_PLUS:   tt = TT_PLUS;
      CH_MINUS:  tt = TT_MINUS;
      CH_QMARK:  tt = TT_PARAM;
      default:   punct_of = 1'b0;
    endcase
  endfunction

  task automatic clear_scan();
    scan_state = MODE_IDLE;
    at_pos   = '0;
    at_line  = LINE_FIRST;
    at_col   = COL_FIRST;
    tok_pos  = '0;
    tok_line = LINE_FIRST;
    tok_col  = COL_FIRST;
  endtask

  task automatic note_rec(input rec_kind_t k, input logic [7:0] vb, input logic [3:0] tt,
                          input logic [OUT_POS_W-1:0] pos, input logic [OUT_LINE_W-1:0] line,
                          input logic [OUT_COL_W-1:0] col, input logic err);
    lex_record_t r;
    r.kind  = k;
    r.vbyte = vb;
    r.tt    = tt;
    r.pos   = pos;
    r.line  = line;
    r.col   = col;
    r.err   = err;
    r.last  = 1'b0;
    beat_records = {beat_records, r};
  endtask

  task automatic note_tok(input rec_kind_t k, input logic [7:0] vb, input logic [3:0] tt);
    note_rec(k, vb, tt, tok_pos, tok_line, tok_col, 1'b0);
  endtask

  task automatic step_counters(input logic [7:0] b);
    if (at_pos != POS_TOP) at_pos = at_pos + 1'b1;
    if (b == CH_NL) begin
      if (at_line != LINE_TOP) at_line = at_line + 1'b1;
      at_col = COL_FIRST;
    end else if (at_col != COL_TOP) begin
      at_col = at_col + 1'b1;
    end
  endtask

  task automatic scan_fresh(input logic [7:0] b);
    logic [3:0] ptt;
    scan_state = MODE_IDLE;
    if (is_blank(b)) begin
      step_counters(b);
    end else begin
      tok_pos  = at_pos;
      tok_line = at_line;
      tok_col  = at_col;
      if (is_letter(b) || b == CH_US) begin
        note_tok(REC_VALUE, b, TT_IDENT);
        scan_state = MODE_IDENT;
        step_counters(b);
      end else if (is_numeral(b)) begin
        note_tok(REC_VALUE, b, TT_NUMBER);
        scan_state = MODE_NUMBER;
        step_counters(b);
      end else if (b == CH_QUOTE) begin
        scan_state = MODE_STRING;
        step_counters(b);
      end else if (punct_of(b, ptt)) begin
        note_tok(REC_VALUE, b, ptt);
        note_tok(REC_CLOSE, '0, ptt);
        step_counters(b);
      end else begin
        note_rec(REC_ERROR, '0, '0, tok_pos, tok_line, tok_col, ERR_UNEXP);
        scan_state = MODE_DEAD;
      end
    end
  endtask

  task automatic lex_beat(input logic kind, input logic [7:0] b);
    logic [3:0] tt;
    bit         more;
    beat_records.delete();
    tt = (scan_state == MODE_IDENT) ? TT_IDENT : TT_NUMBER;
    if (kind == KIND_END) begin
      case (scan_state)
        MODE_DEAD: ;
        MODE_STRING, MODE_ESCAPE:
          note_rec(REC_ERROR, '0, '0, tok_pos, tok_line, tok_col, ERR_UNTERM);
        MODE_IDENT, MODE_NUMBER: begin
          note_tok(REC_CLOSE, '0, tt);
          note_rec(REC_CLOSE, '0, TT_END, at_pos, at_line, at_col, 1'b0);
        end
        default:
          note_rec(REC_CLOSE, '0, TT_END, at_pos, at_line, at_col, 1'b0);
      endcase
      clear_scan();
    end else begin
      case (scan_state)
        MODE_DEAD: ;
        MODE_IDENT, MODE_NUMBER: begin
          more = (scan_state == MODE_IDENT) ? is_name_char(b) : (is_numeral(b) || b == CH_DOT);
          if (more) begin
            note_tok(REC_VALUE, b, tt);
            step_counters(b);
          end else begin
            note_tok(REC_CLOSE, '0, tt);
            scan_fresh(b);
          end
        end
        MODE_STRING: begin
          if (b == CH_QUOTE) begin
            note_tok(REC_CLOSE, '0, TT_STRING);
            scan_state = MODE_IDLE;
          end else if (b == CH_BSLASH) begin
            scan_state = MODE_ESCAPE;
          end else begin
            note_tok(REC_VALUE, b, TT_STRING);
          end
          step_counters(b);
        end
        MODE_ESCAPE: begin
          note_tok(REC_VALUE, b, TT_STRING);
          scan_state = MODE_STRING;
          step_counters(b);
        end
        default: scan_fresh(b);
      endcase
    end
    if (beat_records.size() > 0) beat_records[beat_records.size() - 1].last = 1'b1;
    due_records = {due_records, beat_records};
  endtask

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
  endtask

  task automatic check_record();
    lex_record_t want;
    if (due_records.size() == 0) begin
      fail_count++;
      $display("%0t: record with none expected, expected nothing, actual kind %h type %h",
               $time, out_record_kind, out_token_type);
    end else begin
      want = due_records.pop_front();
      matched_count++;
      if (out_record_kind !== want.kind) flag_field("record_kind", want.kind, out_record_kind);
      if (out_value_byte !== want.vbyte) flag_field("value_byte", want.vbyte, out_value_byte);
      if (out_token_type !== want.tt) flag_field("token_type", want.tt, out_token_type);
      if (out_start_pos !== want.pos) flag_field("start_pos", want.pos, out_start_pos);
      if (out_start_line !== want.line) flag_field("start_line", want.line, out_start_line);
      if (out_start_column !== want.col) flag_field("start_column", want.col, out_start_column);
      if (out_error_code !== want.err) flag_field("error_code", want.err, out_error_code);
      if (out_last !== want.last) flag_field("last", want.last, out_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      due_records.delete();
      fail_count    = 0;
      matched_count = 0;
    end else begin
      if (in_push && !in_full) lex_beat(in_kind, in_char_byte);
      if (out_pop && !out_empty) check_record();
    end
    due_count = due_records.size();
  end

endmodule

@@ bench/testbench.sv @@
// testbench: drives SQL text beats into sql_token_scanner_top with random gaps and
// output stalls; sqlts_stream_checker predicts and checks the records, this module rules.
// Depends on sqlts_pkg, sql_token_scanner_top and sqlts_stream_checker.
module testbench;
  import sqlts_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 100;
  localparam int HOLD_CYCLES  = 300;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_kind;
  logic [7:0]            in_char_byte;
  logic                  out_empty;
  logic                  out_pop;
  logic [1:0]            out_record_kind;
  logic [7:0]            out_value_byte;
  logic [3:0]            out_token_type;
  logic [OUT_POS_W-1:0]  out_start_pos;
  logic [OUT_LINE_W-1:0] out_start_line;
  logic [OUT_COL_W-1:0]  out_start_column;
  logic                  out_error_code;
  logic                  out_last;

  int fail_count;
  int due_count;
  int matched_count;

  int unsigned cycle_count = 0;
  int unsigned live_items  = 0;
  int unsigned statements  = 0;
  bit          count_items = 1'b1;
  bit          push_idle_on = 1'b1;
  bit          pop_idle_on  = 1'b1;
  bit          hold_request = 1'b0;

  string ident_head  = "ABCMXYZabcmxyz_";
  string ident_body  = "ABCMXYZabcmxyz_0123456789.";
  string digits      = "0123456789";
  string number_body = "0123456789.";
  string punct_set   = ",;()*=><+-?";

  sql_token_scanner_top DUT (.*);
  sqlts_stream_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(s.len() - 1, 0)];
  endfunction

  task automatic send_beat(input logic kind, input logic [7:0] b);
    int unsigned gap;
    gap = push_idle_on ? $urandom_range(11, 0) : 0;
    repeat (gap) @(negedge clk);
    in_push      = 1'b1;
    in_kind      = kind;
    in_char_byte = b;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    in_push = 1'b0;
    if (count_items) live_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(KIND_BYTE, s[i]);
  endtask

  task automatic send_end();
    send_beat(KIND_END, 8'($urandom_range(255, 0)));
    statements++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (due_count != 0);
  endtask

  task automatic send_statement();
    int unsigned ntok, pick, len, t;
    logic [7:0]  b;
    ntok = $urandom_range(8, 1);
    for (t = 0; t < ntok; t++) begin
      pick = $urandom_range(19, 0);
      case (pick)
        0, 1, 2, 3, 4: begin
          send_beat(KIND_BYTE, pick_from(ident_head));
          repeat ($urandom_range(4, 0)) send_beat(KIND_BYTE, pick_from(ident_body));
        end
        5, 6, 7: begin
          send_beat(KIND_BYTE, pick_from(digits));
          repeat ($urandom_range(4, 0)) send_beat(KIND_BYTE, pick_from(number_body));
        end
        8, 9, 10: begin
          send_beat(KIND_BYTE, CH_QUOTE);
          len = $urandom_range(5, 0);
          repeat (len) begin
            if ($urandom_range(3, 0) == 0) begin
              send_beat(KIND_BYTE, CH_BSLASH);
              send_beat(KIND_BYTE, 8'($urandom_range(255, 0)));
            end else begin
              b = 8'($urandom_range(255, 0));
              if (b == CH_QUOTE || b == CH_BSLASH) b = CH_SPACE;
              send_beat(KIND_BYTE, b);
            end
          end
          send_beat(KIND_BYTE, CH_QUOTE);
        end
        11, 12, 13, 14: send_beat(KIND_BYTE, pick_from(punct_set));
        15, 16, 17: begin
          if ($urandom_range(1, 0) == 0) send_beat(KIND_BYTE, CH_SPACE);
          else send_beat(KIND_BYTE, 8'($urandom_range(CH_CR, CH_TAB)));
        end
        18: send_beat(KIND_BYTE, 8'($urandom_range(255, 0)));
        default: begin
          // bytes above 0x7f never start a token: the rest of the statement is dropped
          send_beat(KIND_BYTE, 8'($urandom_range(255, 128)));
          count_items = 1'b0;
          repeat ($urandom_range(3, 0)) send_beat(KIND_BYTE, 8'($urandom_range(255, 0)));
          t = ntok;
        end
      endcase
    end
    if (count_items && $urandom_range(7, 0) == 0) begin
      send_beat(KIND_BYTE, CH_QUOTE);
      if ($urandom_range(1, 0) == 0) send_beat(KIND_BYTE, CH_BSLASH);
    end
    send_end();
    count_items = 1'b1;
  endtask

  initial begin
    int unsigned gap;
    out_pop = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = pop_idle_on ? $urandom_range(11, 0) : 0;
      if (gap > 0) begin
        out_pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop = 1'b1;
      do @(posedge clk); while (out_empty);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned first;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_kind      = KIND_BYTE;
    in_char_byte = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    send_text("a1,\"x\\\"");
    send_end();
    send_text("9.\n;()*=><+-?\"k\"_");
    send_end();
    send_text("\"\\");
    send_end();
    send_beat(KIND_BYTE, 8'h00);
    send_beat(KIND_BYTE, 8'hFF);
    send_text("z");
    send_end();
    wait_drained();

    push_idle_on = 1'b0;
    hold_request = 1'b1;
    send_text("a,b;c(d)e*f=g>h<i+j-k?l");
    send_end();
    wait_drained();

    first = live_items;
    while (live_items - first < RANDOM_ITEMS) begin
      push_idle_on = ($urandom_range(3, 0) != 0);
      pop_idle_on  = ($urandom_range(3, 0) != 0);
      send_statement();
    end
    wait_drained();
    repeat (10) @(negedge clk);

    $display("Scanned %0d input beats in %0d statements; %0d records compared.",
             live_items, statements, matched_count);
    $display("Covered all token kinds, both errors, dropped input and a stalled output burst.");
    if (fail_count == 0 && due_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sqlts_pkg.sv
rtl/core/sqlts_front.sv
rtl/core/sqlts_queue.sv
rtl/core/sqlts_back.sv
rtl/core/sql_token_scanner_top.sv
rtl/core/sqlts_checker.sv
bench/sqlts_stream_checker.sv
bench/testbench.sv
